[sv/glb_pkg.sv]
// Shared constants and controller/datapath interface types for the greedy line breaker.
`default_nettype none

package glb_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned LenW        = 6;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;
  localparam int unsigned BufDepthDef = 64;
  localparam int unsigned MaxLenC     = 62;

  localparam logic [LenW-1:0]  LenRst = 6'd25;
  localparam logic [CharW-1:0] NlChar = 8'h0A;
  localparam logic [CharW-1:0] SpChar = 8'h20;

  typedef struct packed {
    logic load;
    logic rd;
    logic nl;
    logic last;
    logic cnt_inc;
    logic brk_commit;
    logic append;
    logic flush_commit;
  } cmd_t;

  typedef struct packed {
    logic need_break;
    logic brk_end;
    logic fl_end;
    logic slot_free;
    logic flush_req;
  } sts_t;

endpackage

`default_nettype wire

[sv/greedy_line_breaker.sv]
// Top level of the greedy line breaker: configuration port, controller and datapath.
`default_nettype none

// The block takes one character per item and emits the wrapped text one character per
// output item, with run_last marking the final character caused by an input item. One
// item is worked on at a time. A line break reads the line store once per emitted
// character through its single read port, emitting the cut + 1 characters up to the
// break point, and a flush on a newline or at the end of text emits every buffered
// character. The line width register answers at addresses 0 to 3; writing it clears
// the buffered line. The line store needs no clearing after reset.
module greedy_line_breaker #(
  parameter int unsigned BufferDepth = glb_pkg::BufDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [glb_pkg::CharW-1:0]   char_in_i,
  input  logic                        text_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [glb_pkg::CharW-1:0]   char_out_o,
  output logic                        run_last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glb_pkg::PaddrW-1:0]  paddr,
  input  logic [glb_pkg::PdataW-1:0]  pwdata,
  output logic [glb_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import glb_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic            cfg_we;
  logic [LenW-1:0] cfg_len;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[PaddrW-1];
  assign prdata = paddr[PaddrW-1] ? '0 : PdataW'(cfg_len);

  glb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glb_dp #(
    .BufferDepth (BufferDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_len_i   (pwdata[LenW-1:0]),
    .cfg_len_o   (cfg_len),
    .char_in_i   (char_in_i),
    .text_end_i  (text_end_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

[sv/glb_ctrl.sv]
// Sequencing state machine of the greedy line breaker.
`default_nettype none

module glb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  glb_pkg::sts_t sts_i,
  output glb_pkg::cmd_t cmd_o
);
  import glb_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StBreak  = 5'b00010,
    StNline  = 5'b00100,
    StAppend = 5'b01000,
    StFlush  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_break ? StBreak : StAppend;
        end
      end
      StBreak: begin
        if (sts_i.slot_free) begin
          cmd_o.rd      = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.brk_end) begin
            state_d = StNline;
          end
        end
      end
      StNline: begin
        if (sts_i.slot_free) begin
          cmd_o.nl         = 1'b1;
          cmd_o.last       = !sts_i.flush_req;
          cmd_o.brk_commit = 1'b1;
          state_d          = StAppend;
        end
      end
      StAppend: begin
        cmd_o.append = 1'b1;
        state_d      = sts_i.flush_req ? StFlush : StIdle;
      end
      StFlush: begin
        if (sts_i.slot_free) begin
          cmd_o.rd      = 1'b1;
          cmd_o.last    = sts_i.fl_end;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.fl_end) begin
            cmd_o.flush_commit = 1'b1;
            state_d            = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/glb_dp.sv]
// Datapath of the greedy line breaker: circular line store, counters and output stages.
`default_nettype none

module glb_dp #(
  parameter int unsigned BufferDepth = glb_pkg::BufDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [glb_pkg::LenW-1:0]   cfg_len_i,
  output logic [glb_pkg::LenW-1:0]   cfg_len_o,
  input  logic [glb_pkg::CharW-1:0]  char_in_i,
  input  logic                       text_end_i,
  input  glb_pkg::cmd_t              cmd_i,
  output glb_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [glb_pkg::CharW-1:0]  char_out_o,
  output logic                       run_last_o
);
  import glb_pkg::*;

  localparam int unsigned AW     = $clog2(BufferDepth);
  localparam int unsigned FW     = AW + 1;
  localparam int unsigned MaxLen = (MaxLenC < BufferDepth) ? MaxLenC : BufferDepth;
  localparam logic [FW-1:0] DepthC = FW'(BufferDepth);

  logic [CharW-1:0] mem [BufferDepth];
  logic [CharW-1:0] rd_q;

  logic [LenW-1:0]  len_q;
  logic [AW-1:0]    head_q;
  logic [FW-1:0]    fill_q;
  logic [AW-1:0]    lsp_q;
  logic [AW-1:0]    cnt_q;
  logic [CharW-1:0] char_q;
  logic             end_q;
  logic             pend_v_q, pend_nl_q, pend_last_q;
  logic             out_v_q, out_last_q;
  logic [CharW-1:0] out_char_q;

  logic [FW-1:0] alen;
  logic [AW-1:0] cut;
  logic [AW-1:0] raddr, waddr, new_head;
  logic          pend_take, push, can_write;

  function automatic logic [AW-1:0] wrap(input logic [FW-1:0] s);
    logic [FW-1:0] r;
    r = (s >= DepthC) ? (s - DepthC) : s;
    return r[AW-1:0];
  endfunction

  always_comb begin
    if (len_q == '0) begin
      alen = FW'(1);
    end else if (int'(len_q) > MaxLen) begin
      alen = FW'(MaxLen);
    end else begin
      alen = FW'(len_q);
    end
  end

  always_comb begin
    logic [FW-1:0] alen_m1;
    logic [FW-1:0] fill_m1;
    alen_m1 = alen - FW'(1);
    fill_m1 = fill_q - FW'(1);
    cut = (lsp_q != '0) ? lsp_q : alen_m1[AW-1:0];
    if ({1'b0, cut} >= fill_q) begin
      cut = fill_m1[AW-1:0];
    end
  end

  assign raddr    = wrap({1'b0, head_q} + {1'b0, cnt_q});
  assign waddr    = wrap({1'b0, head_q} + fill_q);
  assign new_head = wrap({1'b0, head_q} + {1'b0, cut} + FW'(1));

  assign pend_take = pend_v_q && (!out_v_q || out_ready_i);
  assign push      = cmd_i.rd || cmd_i.nl;
  assign can_write = cmd_i.append && (fill_q < DepthC);

  assign sts_o.need_break = (fill_q >= alen);
  assign sts_o.brk_end    = (cnt_q == cut);
  assign sts_o.fl_end     = ({1'b0, cnt_q} == (fill_q - FW'(1)));
  assign sts_o.slot_free  = !pend_v_q || pend_take;
  assign sts_o.flush_req  = (char_q == NlChar) || end_q;

  always_ff @(posedge clk_i) begin
    if (can_write) begin
      mem[waddr] <= char_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_in_i;
      end_q  <= text_end_i;
    end
    if (push) begin
      pend_nl_q   <= cmd_i.nl;
      pend_last_q <= cmd_i.last;
    end
    if (pend_take) begin
      out_char_q <= pend_nl_q ? NlChar : rd_q;
      out_last_q <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LenRst;
      head_q   <= '0;
      fill_q   <= '0;
      lsp_q    <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q  <= cfg_len_i;
        fill_q <= '0;
        lsp_q  <= '0;
      end else if (cmd_i.brk_commit) begin
        head_q <= new_head;
        fill_q <= fill_q - ({1'b0, cut} + FW'(1));
        lsp_q  <= '0;
      end else if (can_write) begin
        fill_q <= fill_q + FW'(1);
        if ((char_q == SpChar) && (fill_q != '0)) begin
          lsp_q <= fill_q[AW-1:0];
        end
      end else if (cmd_i.flush_commit) begin
        head_q <= '0;
        fill_q <= '0;
        lsp_q  <= '0;
      end

      if (cmd_i.load || cmd_i.brk_commit || cmd_i.flush_commit) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AW'(1);
      end

      if (push) begin
        pend_v_q <= 1'b1;
      end else if (pend_take) begin
        pend_v_q <= 1'b0;
      end

      if (pend_take) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign cfg_len_o   = len_q;
  assign out_valid_o = out_v_q;
  assign char_out_o  = out_char_q;
  assign run_last_o  = out_last_q;

endmodule

`default_nettype wire

[sv/glb_checker.sv]
// Port-level assertions for the greedy line breaker and their bind to the top level.
`default_nettype none

module glb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  char_out_o,
  input logic        run_last_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_out_o) && $stable(run_last_o))
    else $error("Output item changed before it was taken.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input was ready again right after an item was accepted.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped.");

  a_len_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] |=> paddr[2] || (prdata[5:0] == $past(pwdata[5:0])))
    else $error("The line width register does not read back the value written.");

endmodule

bind greedy_line_breaker glb_checker u_glb_checker (.*);

`default_nettype wire
